@@ src/mvt_pkg.sv @@
// ----------------------------------------------------------------------------
// mvt_pkg
// Types and constants shared by the 4x4 matrix-vector transform unit.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int LANES     = 4;
  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int ROW_W     = 2;

  localparam logic signed [ELEM_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [ELEM_W-1:0] Q_MIN = 32'sh8000_0000;

  // Request kind carried by an input item
  typedef enum logic [0:0] {
    REQ_LOAD  = 1'b0,
    REQ_XFORM = 1'b1
  } req_t;

  typedef struct packed {
    req_t                     req_type;
    logic [ROW_W-1:0]         row_sel;
    logic signed [ELEM_W-1:0] elem_x;
    logic signed [ELEM_W-1:0] elem_y;
    logic signed [ELEM_W-1:0] elem_z;
    logic signed [ELEM_W-1:0] elem_w;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_x;
    logic signed [ELEM_W-1:0] out_y;
    logic signed [ELEM_W-1:0] out_z;
    logic signed [ELEM_W-1:0] out_w;
    logic                     sat_flag;
  } out_item_t;

  // Row-major coefficient matrix, one vector of four elements
  typedef logic [LANES-1:0][ELEM_W-1:0] vec_t;
  typedef logic [LANES-1:0][LANES-1:0][ELEM_W-1:0] mat_t;
  typedef logic [LANES-1:0][LANES-1:0][PROD_W-1:0] prod_t;

endpackage

@@ src/matrix4_vector_transform.sv @@
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// 4x4 matrix times 4-vector in signed Q16.16, saturated.
// A transform item's result passes the product register, then the result register.
// Throughput: one vector per cycle while out_stall does not back up the pipeline.
// Load items write a matrix row at acceptance and give no result.
// Reset (synchronous): matrix cleared to zero, pipeline emptied.
// ----------------------------------------------------------------------------
module matrix4_vector_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mvt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mvt_pkg::out_item_t out_item
);

  logic          adv;
  logic          p_en;
  logic          accept;
  logic          load_we;
  logic          p_valid;
  mvt_pkg::vec_t vec;
  mvt_pkg::mat_t mat;
  mvt_pkg::prod_t prod;

  // Result register moves when empty or being taken; product register also
  // fills whenever it is empty
  assign adv      = !out_valid || !out_stall;
  assign p_en     = adv || !p_valid;
  assign in_stall = p_valid && !adv;
  assign accept   = in_valid && !in_stall;
  assign load_we  = accept && (in_item.req_type == mvt_pkg::REQ_LOAD);

  assign vec[0] = in_item.elem_x;
  assign vec[1] = in_item.elem_y;
  assign vec[2] = in_item.elem_z;
  assign vec[3] = in_item.elem_w;

  mvt_coeff_store u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (load_we),
    .row   (in_item.row_sel),
    .wdata (vec),
    .mat   (mat)
  );

  mvt_mul_stage u_mul (
    .clk  (clk),
    .en   (p_en),
    .mat  (mat),
    .vec  (vec),
    .prod (prod)
  );

  mvt_sum_stage u_sum (
    .clk  (clk),
    .en   (adv),
    .prod (prod),
    .item (out_item)
  );

  // Advance valid bits; only transform items enter the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p_en) begin
        p_valid <= accept && (in_item.req_type == mvt_pkg::REQ_XFORM);
      end
      if (adv) begin
        out_valid <= p_valid;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (p_valid && out_valid && out_stall))
    else $error("input stalled while pipeline has room");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (adv && in_valid && (in_item.req_type == mvt_pkg::REQ_LOAD)) |=> !p_valid)
    else $error("load item entered the product stage");

  a_result_from_products: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(p_valid))
    else $error("result appeared without a product stage item");
`endif

endmodule

@@ src/mvt_coeff_store.sv @@
// ----------------------------------------------------------------------------
// mvt_coeff_store
// Stored 4x4 coefficient matrix; a load writes one whole row at a time.
// ----------------------------------------------------------------------------
module mvt_coeff_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [mvt_pkg::ROW_W-1:0]     row,
  input  mvt_pkg::vec_t                 wdata,
  output mvt_pkg::mat_t                 mat
);

  mvt_pkg::mat_t coeff;

  // Clear on reset, overwrite the selected row on a load
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (we) begin
      coeff[row] <= wdata;
    end
  end

  assign mat = coeff;

endmodule

@@ src/mvt_mul_stage.sv @@
// ----------------------------------------------------------------------------
// mvt_mul_stage
// Sixteen 32x32 signed products of the matrix with the incoming vector.
// ----------------------------------------------------------------------------
module mvt_mul_stage (
  input  logic          clk,
  input  logic          en,
  input  mvt_pkg::mat_t mat,
  input  mvt_pkg::vec_t vec,
  output mvt_pkg::prod_t prod
);

  mvt_pkg::prod_t prod_next;

  // Form every row-by-column product in parallel
  always_comb begin
    for (int r = 0; r < mvt_pkg::LANES; r++) begin
      for (int c = 0; c < mvt_pkg::LANES; c++) begin
        prod_next[r][c] = $signed(mat[r][c]) * $signed(vec[c]);
      end
    end
  end

  // Hold products while the next stage is blocked
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule

@@ src/mvt_sum_stage.sv @@
// ----------------------------------------------------------------------------
// mvt_sum_stage
// Per-lane sum of products, floor shift by the fraction width, saturation.
// ----------------------------------------------------------------------------
module mvt_sum_stage (
  input  logic               clk,
  input  logic               en,
  input  mvt_pkg::prod_t     prod,
  output mvt_pkg::out_item_t item
);

  localparam int Q_W = mvt_pkg::SUM_W - mvt_pkg::FRAC_BITS;

  logic signed [mvt_pkg::SUM_W-1:0]  sum    [mvt_pkg::LANES];
  logic signed [Q_W-1:0]             q      [mvt_pkg::LANES];
  logic [mvt_pkg::LANES-1:0]         sat_hi;
  logic [mvt_pkg::LANES-1:0]         sat_lo;
  logic [mvt_pkg::LANES-1:0][mvt_pkg::ELEM_W-1:0] lane_val;
  mvt_pkg::out_item_t                item_next;

  // Exact sum, drop fraction bits toward minus infinity, clamp to 32 bits
  always_comb begin
    for (int l = 0; l < mvt_pkg::LANES; l++) begin
      sum[l] = mvt_pkg::SUM_W'($signed(prod[l][0])) + mvt_pkg::SUM_W'($signed(prod[l][1]))
             + mvt_pkg::SUM_W'($signed(prod[l][2])) + mvt_pkg::SUM_W'($signed(prod[l][3]));
      q[l]   = sum[l][mvt_pkg::SUM_W-1:mvt_pkg::FRAC_BITS];
      sat_hi[l] = !q[l][Q_W-1] && (q[l][Q_W-2:mvt_pkg::ELEM_W-1] != '0);
      sat_lo[l] =  q[l][Q_W-1] && (q[l][Q_W-2:mvt_pkg::ELEM_W-1] != '1);
      if (sat_hi[l]) begin
        lane_val[l] = mvt_pkg::Q_MAX;
      end else if (sat_lo[l]) begin
        lane_val[l] = mvt_pkg::Q_MIN;
      end else begin
        lane_val[l] = q[l][mvt_pkg::ELEM_W-1:0];
      end
    end
    item_next.out_x    = lane_val[0];
    item_next.out_y    = lane_val[1];
    item_next.out_z    = lane_val[2];
    item_next.out_w    = lane_val[3];
    item_next.sat_flag = |(sat_hi | sat_lo);
  end

  // Load the result register when it is free or being taken
  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule
